[sv/kts_pkg.sv]
// Shared types, constants and byte-class helpers for the keyword token spotter.
// No dependencies; every other file of the block imports this package.
package kts_pkg;

  localparam int unsigned NUM_KEYWORDS_DEF      = 6;
  localparam int unsigned MAX_KEYWORD_BYTES_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF        = 16;

  localparam int unsigned CFG_DATA_BITS   = 64;
  localparam int unsigned CFG_INDEX_BITS  = 3;
  localparam int unsigned KW_INDEX_BITS   = 3;
  localparam int unsigned MATCH_END_BITS  = 16;

  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [8:0] CASE_DELTA    = 9'd32;

  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_MATCH  = 2'd1,
    ST_END    = 2'd2,
    ST_WAIT   = 2'd3
  } kts_status_t;

  // Per-beat control handed from the sequencer to every matcher.
  typedef struct packed {
    logic       search;    // commit progress this cycle
    logic       restart;   // matchers start from zero
    logic       tok;       // current byte is a token byte
    logic       prev_tok;  // previous byte was a token byte
    logic [7:0] ch;
  } kts_step_t;

  function automatic logic word_byte(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic bytes_match(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] wa;
    logic [8:0] wb;
    wa = {1'b0, a};
    wb = {1'b0, b};
    return (wa == wb) || (wa + CASE_DELTA == wb) || (wb + CASE_DELTA == wa);
  endfunction

endpackage

[sv/kts_kw_regs.sv]
// Keyword configuration registers with a precomputed length per keyword.
// Depends on kts_pkg.
module kts_kw_regs #(
  parameter int unsigned NUM_KEYWORDS      = kts_pkg::NUM_KEYWORDS_DEF,
  parameter int unsigned MAX_KEYWORD_BYTES = kts_pkg::MAX_KEYWORD_BYTES_DEF,
  localparam int unsigned KW_BITS = MAX_KEYWORD_BYTES * 8,
  localparam int unsigned LEN_W   = $clog2(MAX_KEYWORD_BYTES + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [kts_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [kts_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output logic [NUM_KEYWORDS-1:0][KW_BITS-1:0]   kw,
  output logic [NUM_KEYWORDS-1:0][LEN_W-1:0]     kw_len
);
  import kts_pkg::*;

  logic [LEN_W-1:0] wr_len;

  // Length is the count of bytes below the first zero byte.
  always_comb begin
    wr_len = LEN_W'(MAX_KEYWORD_BYTES);
    for (int k = MAX_KEYWORD_BYTES - 1; k >= 0; k--) begin
      if (cfg_data[k*8 +: 8] == 8'h00) begin
        wr_len = LEN_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kw     <= '0;
      kw_len <= '0;
    end else if (cfg_write) begin
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
        if (cfg_index == CFG_INDEX_BITS'(i)) begin
          kw[i]     <= cfg_data[KW_BITS-1:0];
          kw_len[i] <= wr_len;
        end
      end
    end
  end

endmodule

[sv/kts_matcher.sv]
// One keyword matcher: progress register and the per-byte compare.
// Depends on kts_pkg (step struct and byte helpers).
module kts_matcher #(
  parameter int unsigned MAX_KEYWORD_BYTES = kts_pkg::MAX_KEYWORD_BYTES_DEF,
  localparam int unsigned KW_BITS = MAX_KEYWORD_BYTES * 8,
  localparam int unsigned LEN_W   = $clog2(MAX_KEYWORD_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  kts_pkg::kts_step_t st,
  input  logic [KW_BITS-1:0] kw,
  input  logic [LEN_W-1:0]   kw_len,
  output logic               complete
);
  import kts_pkg::*;

  logic [LEN_W-1:0] prog;
  logic [LEN_W-1:0] prog_next;
  logic [LEN_W-1:0] prog_eff;
  logic [LEN_W-1:0] prog_inc;
  logic [7:0]       kbyte;
  logic             hit;

  always_comb begin
    prog_eff = st.restart ? '0 : prog;
    kbyte = 8'h00;
    for (int k = 0; k < MAX_KEYWORD_BYTES; k++) begin
      if (prog_eff == LEN_W'(k)) begin
        kbyte = kw[k*8 +: 8];
      end
    end
    // A fresh start needs a non-token byte before it.
    hit = st.tok && (!st.prev_tok || prog_eff != '0) && (prog_eff < kw_len) &&
          bytes_match(st.ch, kbyte);
    prog_inc  = prog_eff + LEN_W'(1);
    complete  = hit && (prog_inc == kw_len);
    prog_next = (hit && !complete) ? prog_inc : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog <= '0;
    end else if (st.search) begin
      prog <= prog_next;
    end
  end

  property p_prog_below_len;
    @(posedge clk) disable iff (rst)
      (prog != '0) |-> (prog < LEN_W'(MAX_KEYWORD_BYTES));
  endproperty
  a_prog_below_len: assert property (p_prog_below_len)
    else $error("matcher progress reached the keyword size");

endmodule

[sv/keyword_token_spotter.sv]
// Top level of the keyword token spotter: input register, search sequencer,
// matcher array and result register. Depends on kts_pkg, kts_kw_regs, kts_matcher.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------------------
//   text     | text_valid / text_stall  | text_byte, restart, is_final
//   result   | result_valid/result_stall| status, keyword_index, match_end
//   config   | cfg_write                | cfg_index, cfg_data
//
// One byte per cycle, sustained while the result side is not stalled; from accept
// to result a byte passes the input register, then the result register. All
// matchers update together in the cycle a byte leaves the input register. Reset
// leaves the block waiting for a restart with all keywords zero. A stalled result
// holds the result register; the input register then fills and text_stall rises in the same cycle.
module keyword_token_spotter #(
  parameter int unsigned NUM_KEYWORDS      = kts_pkg::NUM_KEYWORDS_DEF,
  parameter int unsigned MAX_KEYWORD_BYTES = kts_pkg::MAX_KEYWORD_BYTES_DEF,
  parameter int unsigned COUNT_BITS        = kts_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  text_valid,
  output logic                                  text_stall,
  input  logic [7:0]                            text_byte,
  input  logic                                  restart,
  input  logic                                  is_final,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [1:0]                            status,
  output logic [kts_pkg::KW_INDEX_BITS-1:0]     keyword_index,
  output logic [kts_pkg::MATCH_END_BITS-1:0]    match_end,
  input  logic                                  cfg_write,
  input  logic [kts_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [kts_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import kts_pkg::*;

  localparam int unsigned KW_BITS = MAX_KEYWORD_BYTES * 8;
  localparam int unsigned LEN_W   = $clog2(MAX_KEYWORD_BYTES + 1);

  logic [NUM_KEYWORDS-1:0][KW_BITS-1:0] kw;
  logic [NUM_KEYWORDS-1:0][LEN_W-1:0]   kw_len;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_restart;
  logic       s1_final;

  // search state
  logic                    prev_tok;
  logic                    prev_tok_next;
  logic [NUM_KEYWORDS-1:0] pending;
  logic [NUM_KEYWORDS-1:0] pending_next;
  logic                    finished;
  logic                    finished_next;
  logic [COUNT_BITS-1:0]   byte_count;
  logic [COUNT_BITS-1:0]   byte_count_next;

  // result register
  kts_status_t                res_status;
  logic [KW_INDEX_BITS-1:0]   res_index;
  logic [MATCH_END_BITS-1:0]  res_end;

  logic                       advance;
  logic                       text_fire;
  kts_step_t                  st;
  logic [NUM_KEYWORDS-1:0]    comp;
  kts_status_t                calc_status;
  logic [KW_INDEX_BITS-1:0]   calc_index;
  logic [COUNT_BITS-1:0]      calc_end;
  logic [31:0]                end_wide;
  logic [MATCH_END_BITS-1:0]  end_sat;
  logic                       fin_eff;
  logic [NUM_KEYWORDS-1:0]    pend_eff;
  logic [COUNT_BITS-1:0]      cnt_eff;
  logic [COUNT_BITS-1:0]      cnt_inc;
  logic                       wb;
  logic                       tok;
  logic                       resolve;
  logic [KW_INDEX_BITS-1:0]   pend_low;
  logic [KW_INDEX_BITS-1:0]   comp_low;

  kts_kw_regs #(
    .NUM_KEYWORDS      (NUM_KEYWORDS),
    .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kw        (kw),
    .kw_len    (kw_len)
  );

  for (genvar g = 0; g < NUM_KEYWORDS; g++) begin : g_match
    kts_matcher #(
      .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES)
    ) u_match (
      .clk      (clk),
      .rst      (rst),
      .st       (st),
      .kw       (kw[g]),
      .kw_len   (kw_len[g]),
      .complete (comp[g])
    );
  end

  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign text_stall = s1_valid && !advance;
  assign text_fire  = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= text_fire || text_stall;
    end
    if (text_fire) begin
      s1_byte    <= text_byte;
      s1_restart <= restart;
      s1_final   <= is_final;
    end
  end

  // lowest set bit wins
  always_comb begin
    pend_low = '0;
    comp_low = '0;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (pend_eff[i]) begin
        pend_low = KW_INDEX_BITS'(i);
      end
      if (comp[i]) begin
        comp_low = KW_INDEX_BITS'(i);
      end
    end
  end

  always_comb begin
    fin_eff  = s1_restart ? 1'b0 : finished;
    pend_eff = s1_restart ? '0 : pending;
    cnt_eff  = s1_restart ? '0 : byte_count;
    cnt_inc  = (cnt_eff == '1) ? cnt_eff : cnt_eff + COUNT_BITS'(1);
    wb       = word_byte(s1_byte);
    tok      = wb || (s1_byte == CH_COLON);
    resolve  = !fin_eff && (pend_eff != '0) && !wb;

    st.search   = advance && !fin_eff && !resolve;
    st.restart  = s1_restart;
    st.tok      = tok;
    st.prev_tok = s1_restart ? 1'b0 : prev_tok;
    st.ch       = s1_byte;

    prev_tok_next   = st.prev_tok;
    pending_next    = pend_eff;
    finished_next   = fin_eff;
    byte_count_next = cnt_eff;
    calc_status     = ST_SEARCH;
    calc_index      = '0;
    calc_end        = '0;

    if (fin_eff) begin
      calc_status = ST_WAIT;
    end else if (resolve) begin
      // lookahead byte closes the token: report, do not count it
      calc_status   = ST_MATCH;
      calc_index    = pend_low;
      calc_end      = cnt_eff;
      pending_next  = '0;
      finished_next = 1'b1;
    end else begin
      byte_count_next = cnt_inc;
      prev_tok_next   = tok;
      if (s1_final) begin
        pending_next  = '0;
        finished_next = 1'b1;
        if (comp != '0) begin
          calc_status = ST_MATCH;
          calc_index  = comp_low;
          calc_end    = cnt_inc;
        end else begin
          calc_status = ST_END;
        end
      end else begin
        pending_next = comp;
      end
    end

    end_wide = 32'(calc_end);
    end_sat  = (end_wide > 32'(MATCH_END_BITS'('1))) ? '1 : end_wide[MATCH_END_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tok   <= 1'b0;
      pending    <= '0;
      finished   <= 1'b1;
      byte_count <= '0;
    end else if (advance) begin
      prev_tok   <= prev_tok_next;
      pending    <= pending_next;
      finished   <= finished_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      res_status <= calc_status;
      res_index  <= calc_index;
      res_end    <= end_sat;
    end
  end

  assign status        = res_status;
  assign keyword_index = res_index;
  assign match_end     = res_end;

  property p_no_pending_when_done;
    @(posedge clk) disable iff (rst)
      finished |-> (pending == '0);
  endproperty
  a_no_pending_when_done: assert property (p_no_pending_when_done)
    else $error("pending keywords while the search is finished");

  property p_match_finishes;
    @(posedge clk) disable iff (rst)
      (advance && (calc_status == ST_MATCH || calc_status == ST_END)) |=> finished;
  endproperty
  a_match_finishes: assert property (p_match_finishes)
    else $error("search did not stop after a match or end of text");

  property p_fields_quiet;
    @(posedge clk) disable iff (rst)
      (result_valid && res_status != ST_MATCH) |-> (res_index == '0 && res_end == '0);
  endproperty
  a_fields_quiet: assert property (p_fields_quiet)
    else $error("index or end set on a result without a match");

  property p_stall_needs_item;
    @(posedge clk) disable iff (rst)
      text_stall |-> (s1_valid && result_valid && result_stall);
  endproperty
  a_stall_needs_item: assert property (p_stall_needs_item)
    else $error("input stalled with room downstream");

endmodule

[tb/keyword_token_spotter_tb.sv]
// Self-checking testbench for keyword_token_spotter: drives text beats and keyword
// settings, predicts every result beat in-line and compares field by field.
// Depends on kts_pkg and the keyword_token_spotter RTL only.
module keyword_token_spotter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kts_pkg::*;

  localparam int unsigned NKW        = NUM_KEYWORDS_DEF;
  localparam int unsigned KW_BYTES   = MAX_KEYWORD_BYTES_DEF;
  localparam int          CASE_STEP  = 32;
  localparam int unsigned SPARE_REG_LO = NKW;
  localparam int unsigned SPARE_REG_HI = NKW + 1;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PRESSURE_HOLD = 150;
  localparam int unsigned SEARCH_GOAL = 700;

  typedef struct packed {
    logic [7:0] ch;
    logic       rs;
    logic       fin;
  } text_beat_t;

  typedef struct packed {
    kts_status_t                status;
    logic [KW_INDEX_BITS-1:0]   kw_idx;
    logic [MATCH_END_BITS-1:0]  end_pos;
  } spot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_stall;
  logic [7:0] text_byte = 8'h20;
  logic restart = 1'b0;
  logic is_final = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] status;
  logic [KW_INDEX_BITS-1:0] keyword_index;
  logic [MATCH_END_BITS-1:0] match_end;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  keyword_token_spotter uut (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_stall(text_stall),
    .text_byte(text_byte), .restart(restart), .is_final(is_final),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .keyword_index(keyword_index), .match_end(match_end),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // spotter shadow state
  logic [63:0]       kw_copy [NKW];
  int unsigned       kw_progress [NKW];
  logic              after_token;
  logic [NKW-1:0]    lookahead_hits;
  logic              search_done;
  logic [15:0]       byte_total;

  text_beat_t   text_q [$];
  spot_result_t verdict_q [$];
  int unsigned  beats_in_flight = 0;
  logic         text_taken = 1'b0;
  text_beat_t   next_beat;
  int unsigned  tx_gap = 0;
  bit           tx_burst = 1'b0;
  bit           rx_quiet = 1'b0;
  int unsigned  rx_stall_left = 0;
  int unsigned  hold_left = 0;
  int unsigned  pressure_asked = 0;
  int unsigned  pressure_served = 0;

  int unsigned failures = 0;
  int unsigned results_seen = 0;
  int unsigned searched_beats = 0;
  int unsigned match_count = 0;
  int unsigned miss_count = 0;
  int unsigned idle_beats = 0;
  int unsigned settings_used = 0;

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == CH_UNDERSCORE;
  endfunction

  function automatic bit chars_agree(logic [7:0] a, logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d == 0 || d == CASE_STEP || d == -CASE_STEP;
  endfunction

  function automatic int unsigned key_len(logic [63:0] w);
    for (int k = 0; k < KW_BYTES; k++)
      if (w[8*k +: 8] == 8'h00) return k;
    return KW_BYTES;
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < NKW; i++) kw_progress[i] = 0;
    after_token = 1'b0;
    lookahead_hits = '0;
    byte_total = '0;
  endfunction

  function automatic spot_result_t scan_byte(text_beat_t b);
    spot_result_t r;
    logic tok;
    logic hit;
    int unsigned n;
    int unsigned prog;
    r = '{status: ST_SEARCH, kw_idx: '0, end_pos: '0};
    hit = 1'b0;
    if (b.rs) begin
      clear_scan();
      search_done = 1'b0;
    end
    if (search_done) begin
      r.status = ST_WAIT;
    end else if (lookahead_hits != '0 && !is_word_char(b.ch)) begin
      // lowest pending keyword wins; the lookahead byte itself is not counted
      for (int i = NKW - 1; i >= 0; i--)
        if (lookahead_hits[i]) r.kw_idx = KW_INDEX_BITS'(i);
      r.status = ST_MATCH;
      r.end_pos = byte_total;
      lookahead_hits = '0;
      search_done = 1'b1;
    end else begin
      lookahead_hits = '0;
      if (byte_total != 16'hFFFF) byte_total = byte_total + 16'd1;
      tok = is_word_char(b.ch) || b.ch == CH_COLON;
      for (int i = 0; i < NKW && !hit; i++) begin
        n = key_len(kw_copy[i]);
        prog = kw_progress[i];
        if (tok && (!after_token || prog != 0) && prog < n &&
            chars_agree(b.ch, kw_copy[i][8*prog +: 8])) begin
          prog++;
          if (prog == n) begin
            prog = 0;
            if (b.fin) begin
              hit = 1'b1;
              r.kw_idx = KW_INDEX_BITS'(i);
            end else begin
              lookahead_hits[i] = 1'b1;
            end
          end
        end else begin
          prog = 0;
        end
        kw_progress[i] = prog;
      end
      after_token = tok;
      if (hit) begin
        r.status = ST_MATCH;
        r.end_pos = byte_total;
        search_done = 1'b1;
      end else if (b.fin) begin
        r.status = ST_END;
        lookahead_hits = '0;
        search_done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int unsigned next_tx_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // text side: present a beat, hold it until taken, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (!text_valid || text_taken) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        text_valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        next_beat = text_q.pop_front();
        text_byte <= next_beat.ch;
        restart <= next_beat.rs;
        is_final <= next_beat.fin;
        text_valid <= 1'b1;
        tx_gap = next_tx_gap();
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  // result side stall pattern, including the long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (pressure_served != pressure_asked) begin
      pressure_served = pressure_asked;
      hold_left = PRESSURE_HOLD - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else if (rx_quiet) begin
      result_stall <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left = rx_stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 9) < 7) begin
        result_stall <= 1'b0;
      end else begin
        rx_stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) :
                                                     $urandom_range(8, 40);
        result_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    spot_result_t want;
    if (rst) begin
      text_taken <= 1'b0;
    end else begin
      text_taken <= text_valid && !text_stall;
      if (text_valid && !text_stall) begin
        want = scan_byte('{ch: text_byte, rs: restart, fin: is_final});
        verdict_q.push_back(want);
        beats_in_flight--;
        case (want.status)
          ST_WAIT:  idle_beats++;
          ST_MATCH: match_count++;
          ST_END:   miss_count++;
          default:  ;
        endcase
        if (want.status != ST_WAIT) searched_beats++;
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("result beat %0d arrived with nothing expected: status %0d index %0d end %0d",
                     results_seen, status, keyword_index, match_end);
        end else begin
          want = verdict_q.pop_front();
          if (status !== want.status || keyword_index !== want.kw_idx ||
              match_end !== want.end_pos) begin
            failures++;
            if (failures <= 10)
              $display("result beat %0d: status %0d/%0d index %0d/%0d end %0d/%0d (exp/got)",
                       results_seen, want.status, status, want.kw_idx, keyword_index,
                       want.end_pos, match_end);
          end
        end
      end
    end
  end

  function automatic logic [63:0] pack_word(string s);
    logic [63:0] w;
    w = '0;
    for (int k = 0; k < s.len() && k < KW_BYTES; k++) w[8*k +: 8] = s[k];
    return w;
  endfunction

  function automatic logic [7:0] sep_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return " ";
    c = 8'($urandom_range(0, 255));
    while (is_word_char(c) || c == CH_COLON) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] token_char();
    string pool;
    pool = "abcqzAZ_09";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [63:0] random_keyword(bit full);
    string pool;
    logic [63:0] w;
    int unsigned n;
    int unsigned r;
    pool = "aabbc_:1Zz";
    w = '0;
    r = $urandom_range(0, 99);
    if (!full && r < 5) return w;
    n = full ? KW_BYTES : (($urandom_range(0, 9) == 0) ? KW_BYTES : $urandom_range(1, 4));
    for (int k = 0; k < n; k++) w[8*k +: 8] = pool[$urandom_range(0, pool.len() - 1)];
    if (!full && r < 9) begin
      // a high byte; only a lowercase letter 32 below it can match it
      w[8*$urandom_range(0, n - 1) +: 8] = 8'($urandom_range(128, 255));
    end else if (!full && r < 13 && n < KW_BYTES - 1) begin
      // junk above the terminating zero byte
      w[8*(n + 1) +: 8] = 8'($urandom_range(1, 255));
    end
    return w;
  endfunction

  task automatic queue_beat(logic [7:0] ch, bit rs = 1'b0, bit fin = 1'b0);
    text_q.push_back('{ch: ch, rs: rs, fin: fin});
    beats_in_flight++;
  endtask

  task automatic queue_str(string s, bit rs, bit fin);
    for (int k = 0; k < s.len(); k++)
      queue_beat(s[k], rs && k == 0, fin && k == s.len() - 1);
  endtask

  // one search: keywords (mangled at times) between separators, tokens and noise
  task automatic queue_text();
    logic [7:0] txt [$];
    logic [63:0] w;
    logic [7:0] b;
    int unsigned segs;
    int unsigned r;
    int unsigned n;
    int unsigned cut;
    int unsigned bad;
    bit last_fin;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        w = kw_copy[$urandom_range(0, NKW - 1)];
        n = key_len(w);
        if (txt.size() != 0 && $urandom_range(0, 3) != 0) txt.push_back(sep_char());
        cut = (n > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : n;
        bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KW_BYTES - 1) : KW_BYTES;
        for (int k = 0; k < cut; k++) begin
          b = w[8*k +: 8];
          if ($urandom_range(0, 3) == 0) b = b ^ 8'h20;
          if (k == bad) b = 8'($urandom_range(1, 255));
          txt.push_back(b);
        end
        r = $urandom_range(0, 99);
        if (r < 55) txt.push_back(sep_char());
        else if (r < 65) txt.push_back(CH_COLON);
        else if (r < 85) txt.push_back(token_char());
      end else if (r < 75) begin
        repeat ($urandom_range(1, 6)) txt.push_back(token_char());
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) txt.push_back(sep_char());
      end else begin
        repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (txt.size() == 0) txt.push_back(sep_char());
    last_fin = ($urandom_range(0, 4) != 0);
    for (int k = 0; k < txt.size(); k++)
      queue_beat(txt[k], k == 0, last_fin && k == txt.size() - 1);
    // stray beats with no restart
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3))
        queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic write_keyword(int unsigned idx, logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_INDEX_BITS'(idx);
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx < NKW) kw_copy[idx] = val;
  endtask

  task automatic settle();
    while (beats_in_flight != 0 || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned phase;
    for (int i = 0; i < NKW; i++) kw_copy[i] = '0;
    clear_scan();
    search_done = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // out of reset the block waits for a restart
    queue_beat("a");
    settle();

    write_keyword(0, pack_word("if"));
    write_keyword(1, pack_word("IF"));
    write_keyword(2, pack_word("x:y"));
    write_keyword(3, pack_word("a"));
    write_keyword(4, 64'hFFFF_FFFF_FFFF_FFFF);
    write_keyword(5, pack_word("zz"));
    write_keyword(SPARE_REG_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_keyword(SPARE_REG_HI, pack_word("q"));
    settings_used++;

    queue_str(" iF ", 1'b1, 1'b0);   // two keywords end together
    queue_beat("q");                 // finished, no restart
    queue_str("x:Y_", 1'b1, 1'b0);   // lookahead fails on underscore
    queue_beat(8'h00);
    queue_beat("a");
    queue_beat(8'hFF);               // high byte resolves the lookahead
    queue_str("zZ", 1'b1, 1'b1);     // keyword ends on the last byte
    queue_str("zzz!", 1'b1, 1'b1);   // no retry of a shorter prefix
    queue_str("a:", 1'b1, 1'b1);     // colon resolves the lookahead
    queue_beat(8'h80, 1'b1, 1'b1);
    settle();

    phase = 0;
    while (searched_beats + idle_beats < SEARCH_GOAL) begin
      for (int i = 0; i < NKW; i++) write_keyword(i, random_keyword(phase == 1));
      if (phase == 1) write_keyword(3, '0);
      if ($urandom_range(0, 3) == 0)
        write_keyword($urandom_range(SPARE_REG_LO, SPARE_REG_HI), random_keyword(1'b0));
      settings_used++;
      tx_burst = (phase == 0) || ($urandom_range(0, 3) == 0);
      rx_quiet = (phase != 0) && ($urandom_range(0, 4) == 0);
      if (phase == 0) pressure_asked++;
      repeat ($urandom_range(4, 10)) queue_text();
      settle();
      phase++;
    end

    $display("covered %0d searched bytes: %0d matches, %0d texts without a match, %0d idle bytes",
             searched_beats, match_count, miss_count, idle_beats);
    $display("%0d keyword settings, %0d result beats checked, %0d failures",
             settings_used, results_seen, failures);
    if (failures == 0) begin
      $display("keyword_token_spotter verification clean");
    end else begin
      $display("keyword_token_spotter verification failed");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("keyword_token_spotter verification failed");
    $finish;
  end

endmodule
